### hdl/p4td_pkg.sv
package p4td_pkg;

  localparam int unsigned RowCount  = 8;
  localparam int unsigned PixelBits = 4;
  localparam int unsigned RowBits   = $clog2(RowCount);
  localparam int unsigned PosBits   = 5;

  // One row of work handed from the front to the back.
  typedef struct packed {
    logic [7:0]         plane_0;
    logic [7:0]         plane_1;
    logic [7:0]         plane_2;
    logic [7:0]         plane_3;
    logic [RowBits-1:0] row;
  } row_job_t;

  typedef logic [PixelBits-1:0] pixel_t;

  // Pixel x takes bit (7 - x) of each plane, plane 0 in the lsb.
  function automatic pixel_t pixel_at(input row_job_t job, input logic [2:0] x);
    logic [2:0] b;
    b = 3'd7 - x;
    return {job.plane_3[b], job.plane_2[b], job.plane_1[b], job.plane_0[b]};
  endfunction

endpackage

### hdl/p4td_byte_if.sv
interface p4td_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

### hdl/p4td_row_if.sv
interface p4td_row_if;
  logic                    valid;
  logic                    ready;
  p4td_pkg::pixel_t        pixel_0;
  p4td_pkg::pixel_t        pixel_1;
  p4td_pkg::pixel_t        pixel_2;
  p4td_pkg::pixel_t        pixel_3;
  p4td_pkg::pixel_t        pixel_4;
  p4td_pkg::pixel_t        pixel_5;
  p4td_pkg::pixel_t        pixel_6;
  p4td_pkg::pixel_t        pixel_7;
  logic [2:0]              row_index;
  logic                    tile_done;

  modport source (
    output valid, output pixel_0, output pixel_1, output pixel_2, output pixel_3,
    output pixel_4, output pixel_5, output pixel_6, output pixel_7,
    output row_index, output tile_done, input ready
  );
  modport sink (
    input valid, input pixel_0, input pixel_1, input pixel_2, input pixel_3,
    input pixel_4, input pixel_5, input pixel_6, input pixel_7,
    input row_index, input tile_done, output ready
  );
endinterface

### hdl/p4td_front.sv
module p4td_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  p4td_byte_if.sink           byte_i,
  input  logic                q_full_i,
  output logic                push_o,
  output p4td_pkg::row_job_t  job_o
);

  logic [p4td_pkg::PosBits-1:0] pos_q, pos_d;
  logic [15:0]                  low_rows_q [p4td_pkg::RowCount];
  logic [7:0]                   plane_2_q;
  logic [p4td_pkg::RowBits-1:0] row;
  logic                         is_plane_3;
  logic                         accept;

  assign row        = pos_q[p4td_pkg::RowBits:1];
  assign is_plane_3 = pos_q[p4td_pkg::PosBits-1] & pos_q[0];
  // only the plane 3 byte needs queue room
  assign byte_i.ready = ~(is_plane_3 & q_full_i);
  assign accept       = byte_i.valid & byte_i.ready;
  assign pos_d        = pos_q + 1'b1;

  assign push_o        = accept & is_plane_3;
  assign job_o.plane_0 = low_rows_q[row][7:0];
  assign job_o.plane_1 = low_rows_q[row][15:8];
  assign job_o.plane_2 = plane_2_q;
  assign job_o.plane_3 = byte_i.data_byte;
  assign job_o.row     = row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !pos_q[p4td_pkg::PosBits-1]) begin
      if (!pos_q[0]) begin
        low_rows_q[row][7:0] <= byte_i.data_byte;
      end else begin
        low_rows_q[row][15:8] <= byte_i.data_byte;
      end
    end
    if (accept && pos_q[p4td_pkg::PosBits-1] && !pos_q[0]) begin
      plane_2_q <= byte_i.data_byte;
    end
  end

endmodule

### hdl/p4td_queue.sv
module p4td_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  p4td_pkg::row_job_t  job_i,
  output logic                full_o,
  input  logic                pop_i,
  output p4td_pkg::row_job_t  job_o,
  output logic                empty_o
);

  p4td_pkg::row_job_t slot_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### hdl/p4td_back.sv
module p4td_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  p4td_pkg::row_job_t  job_i,
  output logic                pop_o,
  p4td_row_if.source          row_o
);

  logic                         valid_q;
  p4td_pkg::pixel_t             pix_q [8];
  logic [p4td_pkg::RowBits-1:0] row_q;
  logic                         done_q;

  assign pop_o = ~empty_i & (~valid_q | row_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (row_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int x = 0; x < 8; x++) begin
        pix_q[x] <= p4td_pkg::pixel_at(job_i, 3'(x));
      end
      row_q  <= job_i.row;
      done_q <= &job_i.row;
    end
  end

  assign row_o.valid     = valid_q;
  assign row_o.pixel_0   = pix_q[0];
  assign row_o.pixel_1   = pix_q[1];
  assign row_o.pixel_2   = pix_q[2];
  assign row_o.pixel_3   = pix_q[3];
  assign row_o.pixel_4   = pix_q[4];
  assign row_o.pixel_5   = pix_q[5];
  assign row_o.pixel_6   = pix_q[6];
  assign row_o.pixel_7   = pix_q[7];
  assign row_o.row_index = row_q;
  assign row_o.tile_done = done_q;

endmodule

### hdl/planar_4bpp_tile_decoder_unit.sv
// Planar 4bpp tile decoder.
// tile_byte_i: one tile byte per item, 32 items per 8x8 tile in planar order
//   (planes 0/1 interleaved per row, then planes 2/3 interleaved per row).
// pixel_row_o: one item per row, made when the row's plane 3 byte arrives:
//   eight 4-bit colour indices (leftmost first), row number, last-row flag.
// Throughput: one byte per cycle sustained; the front only stalls a plane 3
//   byte when the two-entry row queue is full.
// Path: an accepted plane 3 byte is written into the row queue, then moved
//   into the back's output register, which presents the row item.
// Receiver stall: the output register holds, the queue fills, and only then
//   is tile_byte_i.ready dropped on a plane 3 byte; other bytes keep flowing.
// Reset: byte position returns to the start of a tile, queue and output are
//   emptied. Row store contents are not cleared; each entry is written before
//   it is read within a tile.
module planar_4bpp_tile_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  p4td_byte_if.sink   tile_byte_i,
  p4td_row_if.source  pixel_row_o
);

  p4td_pkg::row_job_t push_job, head_job;
  logic               push, pop, q_full, q_empty;

  // front: byte position, plane 0/1 row store, plane 2 hold
  p4td_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (tile_byte_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  // decoupling queue between the two halves
  p4td_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty)
  );

  // back: bit-plane merge into the output register
  p4td_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .job_i   (head_job),
    .pop_o   (pop),
    .row_o   (pixel_row_o)
  );

endmodule

### tb/sv/planar_4bpp_tile_decoder_unit_tb.sv
`timescale 1ns / 100ps

// Testbench for the planar 4bpp tile decoder.
// Tile bytes go in on tile_byte_i, one per item; decoded rows come back on
// pixel_row_o. A predictor in here tracks the byte position and the row store
// and queues the row item that every plane 3 byte should give. Each row item
// that comes out is checked field by field against the oldest queued row.
module planar_4bpp_tile_decoder_unit_tb;

  localparam int unsigned IdlePercent   = 10;   // rough idle rate on either side
  localparam int unsigned HoldOffCycles = 300;  // long receiver hold-off
  localparam int unsigned DrainCycles   = 8;    // settle time after the last row
  localparam int unsigned StallLimit    = 2000; // cycles without any item moving
  localparam int unsigned RandomTiles   = 19;
  localparam int unsigned SteadyTiles   = 4;

  // One decoded row as the checker expects it.
  typedef struct packed {
    p4td_pkg::pixel_t [7:0] pixel;
    logic [2:0]             row_index;
    logic                   tile_done;
  } pixel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  p4td_byte_if byte_if ();
  p4td_row_if  row_if ();

  planar_4bpp_tile_decoder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tile_byte_i (byte_if),
    .pixel_row_o (row_if)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: position in the tile, plane 0/1 pair per row
  // (plane 0 in the low byte), and the plane 2 byte of the current row.
  logic [4:0]  tile_pos;
  logic [15:0] low_planes [8];
  logic [7:0]  plane_2_hold;

  pixel_row_t  pending_rows[$];
  int unsigned mismatches = 0;

  // Flow control shared between the stimulus and the receiver process.
  bit          steady_flow = 1'b0; // no idling on either side while set
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;

  // Advance the predictor by one accepted byte. Bytes in the first half of
  // the tile (tile_pos[4] low) fill the plane 0/1 store; in the second half
  // the even byte is plane 2 and the odd one, plane 3, completes the row.
  task automatic decode_byte(input logic [7:0] b);
    logic [2:0]  row;
    logic [2:0]  bit_sel;
    pixel_row_t  decoded;
    row = tile_pos[3:1];
    if (!tile_pos[4]) begin
      if (!tile_pos[0]) low_planes[row][7:0] = b;
      else low_planes[row][15:8] = b;
    end else if (!tile_pos[0]) begin
      plane_2_hold = b;
    end else begin
      // Pixel x comes from bit 7 - x of every plane, leftmost pixel first.
      for (int x = 0; x < 8; x++) begin
        bit_sel = 3'(7 - x);
        decoded.pixel[x] = {b[bit_sel], plane_2_hold[bit_sel],
                            low_planes[row][8 + bit_sel], low_planes[row][bit_sel]};
      end
      decoded.row_index = row;
      decoded.tile_done = (row == 3'd7);
      pending_rows.push_back(decoded);
    end
    tile_pos = tile_pos + 5'd1; // wraps to the next tile after byte 31
  endtask

  task automatic check_row();
    pixel_row_t       want;
    p4td_pkg::pixel_t got [8];
    if (pending_rows.size() == 0) begin
      $display("%0t: row item with none expected, row %0d", $time, row_if.row_index);
      mismatches++;
      return;
    end
    want = pending_rows.pop_front();
    got = '{row_if.pixel_0, row_if.pixel_1, row_if.pixel_2, row_if.pixel_3,
            row_if.pixel_4, row_if.pixel_5, row_if.pixel_6, row_if.pixel_7};
    for (int x = 0; x < 8; x++) begin
      if (got[x] !== want.pixel[x]) begin
        $display("%0t: pixel_%0d expected %0h actual %0h", $time, x, want.pixel[x], got[x]);
        mismatches++;
      end
    end
    if (row_if.row_index !== want.row_index) begin
      $display("%0t: row_index expected %0d actual %0d", $time, want.row_index,
               row_if.row_index);
      mismatches++;
    end
    if (row_if.tile_done !== want.tile_done) begin
      $display("%0t: tile_done expected %0b actual %0b", $time, want.tile_done,
               row_if.tile_done);
      mismatches++;
    end
  endtask

  // Sample both channels at the rising edge. Outputs are checked before the
  // new byte is predicted; the block's latency keeps the two apart anyway.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (row_if.valid && row_if.ready) check_row();
      if (byte_if.valid && byte_if.ready) decode_byte(byte_if.data_byte);
    end
  end

  // Watchdog: any cycle where neither channel moves counts toward the limit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_if.valid && byte_if.ready) || (row_if.valid && row_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("%0t: no item moved for %0d cycles", $time, StallLimit);
          $display("FAIL planar_4bpp_tile_decoder_unit");
          $finish;
        end
      end
    end
  end

  // Receiver: random back-pressure, a quiet stretch on request, and a long
  // hold-off counted down here so the sender keeps pushing meanwhile.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      row_if.ready <= 1'b0;
      hold_left--;
    end else if (steady_flow) begin
      row_if.ready <= 1'b1;
    end else begin
      row_if.ready <= ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // Offer one byte, with a random gap first, and return at the falling edge
  // after it was taken. valid is left high so back-to-back items run on.
  task automatic send_byte(input logic [7:0] b);
    while (!steady_flow && $urandom_range(0, 99) < IdlePercent) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_bytes(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Sender pause: stop offering until every queued row has come out.
  task automatic drain_rows();
    byte_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_rows.size() != 0) @(negedge clk_i);
  endtask

  // One hand-picked tile: all-zero and all-one rows, rows that walk through
  // every colour index, single-bit planes, and the last row with tile_done.
  task automatic test_directed_tile();
    logic [7:0] tile_bytes [32];
    tile_bytes = '{
      8'h00, 8'h00, 8'hFF, 8'hFF, 8'hAA, 8'hCC, 8'hAA, 8'hCC,
      8'h55, 8'h33, 8'h80, 8'h01, 8'h0F, 8'hF0, 8'hFF, 8'h00,
      8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0, 8'h00, 8'hF0, 8'hFF,
      8'h0F, 8'hFF, 8'h7E, 8'h81, 8'h3C, 8'hC3, 8'hFF, 8'h00
    };
    foreach (tile_bytes[i]) send_byte(tile_bytes[i]);
  endtask

  // Bulk of the run: random tile content with idling on both sides. The
  // position wraps from one tile into the next throughout.
  task automatic test_random_tiles();
    send_random_bytes(RandomTiles * 32);
  endtask

  // A stretch with no idling at all, so rows come out at full rate.
  task automatic test_full_rate();
    steady_flow = 1'b1;
    send_random_bytes(SteadyTiles * 32);
    steady_flow = 1'b0;
  endtask

  // Receiver holds off for a long stretch while bytes keep coming; the row
  // queue fills and the block must stall a plane 3 byte without losing rows.
  task automatic test_receiver_hold_off();
    hold_req = 1'b1;
    send_random_bytes(64);
  endtask

  // Sender pauses mid-tile until everything has drained, then carries on
  // from the same byte position.
  task automatic test_sender_pause();
    send_random_bytes(21);
    drain_rows();
    send_random_bytes(43);
  endtask

  initial begin
    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'h00;
    tile_pos          = '0;
    plane_2_hold      = '0;
    foreach (low_planes[i]) low_planes[i] = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_tile();
    test_full_rate();
    test_random_tiles();
    test_receiver_hold_off();
    test_sender_pause();
    test_random_tiles();

    byte_if.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("PASS planar_4bpp_tile_decoder_unit");
    end else begin
      $display("FAIL planar_4bpp_tile_decoder_unit");
    end
    $finish;
  end

endmodule
